// ===== src/sparse_index_value_table_unit_defines.svh =====
// Assertion macros shared by the sparse index/value table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SPARSE_INDEX_VALUE_TABLE_UNIT_DEFINES_SVH
`define SPARSE_INDEX_VALUE_TABLE_UNIT_DEFINES_SVH

// Implication check under clock and async reset.
`define SIVT_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check.
`define SIVT_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/sivt_pkg.sv =====
// Types and constants for the sparse index/value table.
// No dependencies.
package sivt_pkg;
    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_MAX    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  rdata;
        logic [DATA_W-1:0]  maxk;
    } rsp_t;
endpackage

// ===== src/sivt_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on sivt_pkg.
module sivt_front
    import sivt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req_in,
    output logic req_valid,
    input  logic req_take,
    output req_t req_out
);
    req_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full      = cnt_reg == 2'd2;
    assign req_valid = cnt_reg != 2'd0;
    assign req_out   = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

// ===== src/sivt_back.sv =====
// Back end: scans all slots in turn for each request, then writes back.
// Depends on sivt_pkg and the assertion macro header.
`include "sparse_index_value_table_unit_defines.svh"
module sivt_back
    import sivt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_take,
    input  req_t req_in,
    input  logic empty_in,
    output logic rsp_valid,
    input  logic rsp_pop,
    output rsp_t rsp_out
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WAIT = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    logic [CAPACITY-1:0] valid_reg;
    logic [KEY_W-1:0]    key_mem [CAPACITY];
    logic [DATA_W-1:0]   val_mem [CAPACITY];

    state_t            state_reg, state_next;
    req_t              cur_reg;
    logic [IW-1:0]     idx_reg;
    logic              rd_v_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [DATA_W-1:0] rd_val_reg;
    logic              hit_reg, free_reg, any_reg;
    logic [IW-1:0]     hit_idx_reg, free_idx_reg;
    logic [KEY_W-1:0]  best_reg;
    logic [DATA_W-1:0] hval_reg;
    rsp_t              res_reg;
    rsp_t              rsp_reg;
    logic              rsp_v_reg;
    logic              last_issue;
    logic              entry_v;

    assign req_take  = state_reg == S_IDLE && req_valid;
    assign rsp_valid = rsp_v_reg;
    assign rsp_out   = rsp_reg;
    assign last_issue = idx_reg == IW'(CAPACITY - 1);
    assign entry_v   = valid_reg[rd_idx_reg];

    // memory read port, registered
    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
        rd_idx_reg <= idx_reg;
        if (state_reg == S_DONE && cur_reg.op == OP_SET && (hit_reg || free_reg))
        begin
            key_mem[hit_reg ? hit_idx_reg : free_idx_reg] <= cur_reg.key;
            val_mem[hit_reg ? hit_idx_reg : free_idx_reg] <= cur_reg.data;
        end
    end

    // the last slot read is compared during S_WAIT, before the verdict
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_valid) state_next = S_SCAN;
            S_SCAN: if (last_issue) state_next = S_WAIT;
            S_WAIT: state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT:  if (!rsp_v_reg || rsp_pop) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            rsp_v_reg <= 1'b0;
            rd_v_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= state_reg == S_SCAN;
            if (req_take)
            begin
                cur_reg <= req_in;
                idx_reg <= '0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
                any_reg <= 1'b0;
            end
            if (state_reg == S_SCAN && !last_issue) idx_reg <= idx_reg + 1'b1;
            // compare one slot per cycle
            if (rd_v_reg)
            begin
                if (entry_v && rd_key_reg == cur_reg.key && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                    hval_reg    <= rd_val_reg;
                end
                if (!entry_v && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (entry_v && (!any_reg || rd_key_reg > best_reg))
                begin
                    any_reg  <= 1'b1;
                    best_reg <= rd_key_reg;
                end
            end
            if (state_reg == S_DONE)
            begin
                res_reg.rdata  <= '0;
                res_reg.maxk   <= '0;
                res_reg.status <= ST_OK;
                unique case (cur_reg.op)
                    OP_SET:
                    begin
                        if (hit_reg) valid_reg[hit_idx_reg] <= 1'b1;
                        else if (free_reg) valid_reg[free_idx_reg] <= 1'b1;
                        else res_reg.status <= ST_FULL;
                    end
                    OP_GET:
                    begin
                        if (hit_reg) res_reg.rdata <= hval_reg;
                        else res_reg.status <= ST_NOT_FOUND;
                    end
                    OP_DELETE:
                    begin
                        if (hit_reg) valid_reg[hit_idx_reg] <= 1'b0;
                        else res_reg.status <= ST_NOT_FOUND;
                    end
                    OP_MAX:
                        res_reg.maxk <= any_reg ? {1'b0, best_reg} : '1;
                    default: res_reg.status <= ST_OK;
                endcase
            end
            // move the finished result out once the output register is free
            if (state_reg == S_OUT && (!rsp_v_reg || rsp_pop))
            begin
                rsp_reg   <= res_reg;
                rsp_v_reg <= 1'b1;
            end
            else if (rsp_pop && rsp_v_reg)
            begin
                rsp_v_reg <= 1'b0;
            end
        end
    end

    `SIVT_ASSERT_IMP(a_take_idle, clk, rst_n, req_take, state_reg == S_IDLE)
    `SIVT_ASSERT_IMP(a_empty_match, clk, rst_n, 1'b1, empty_in == !rsp_v_reg)
    `SIVT_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == S_DONE, state_reg == S_OUT)
    `SIVT_ASSERT_IMP(a_status_legal, clk, rst_n, rsp_v_reg, rsp_reg.status != ST_RSVD)
endmodule

// ===== src/sparse_index_value_table_unit.sv =====
// Top level of the sparse index/value table.
// Depends on sivt_pkg, sivt_front and sivt_back.
//
// Usage: requests enter through a queue-like port (push/full). Each request
// carries op (set, get, delete, max), key_index and write_data. Exactly one
// result comes back per request through a queue-like port (empty/pop) with
// status, read_data and max_key.
// Processing: a request leaves the request queue, then the back end reads
// every slot in turn, compares the last slot read, decides, and loads the
// output register. The back end walks every slot once through one key
// equality comparator, one key magnitude comparator and one memory read
// port, and takes no new request until the current one has reached the
// output register.
// A two-entry request queue decouples the input side, so up to two further
// requests are taken while one is being worked on. A finished result waits
// in the output register; the back end may finish the next request and hold
// it until that register frees. When the receiver stalls, the back end holds
// and the request queue fills, then full rises.
// Reset clears all slot valid marks at once (table empty), empties the
// request queue and drops any waiting result. Key and value memories are
// not cleared; a slot's contents are used only while it is valid.
module sparse_index_value_table_unit
    import sivt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        op,
    input  logic [30:0]       key_index,
    input  logic signed [31:0] write_data,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic signed [31:0] read_data,
    output logic signed [31:0] max_key
);
    req_t req_in, req_q;
    rsp_t rsp;
    logic req_valid, req_take, rsp_valid;

    assign req_in.op   = op_t'(op);
    assign req_in.key  = key_index;
    assign req_in.data = write_data;

    // hold requests in a short queue
    sivt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_in    (req_in),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_out   (req_q)
    );

    // scan the table and produce one result per request
    sivt_back #(.CAPACITY(CAPACITY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_in    (req_q),
        .empty_in  (empty),
        .rsp_valid (rsp_valid),
        .rsp_pop   (pop),
        .rsp_out   (rsp)
    );

    assign empty     = !rsp_valid;
    assign status    = rsp.status;
    assign read_data = rsp.rdata;
    assign max_key   = rsp.maxk;
endmodule
